[sv/mnb_pkg.sv]
// Shared types, codes and constants of the maze navigation controller.
package mnb_pkg;

   localparam int LOG_DEPTH = 64;
   localparam int DEPTH_W   = $clog2(LOG_DEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [9:0]           dist_type;
   typedef logic [7:0]           tol_type;
   typedef logic [15:0]          ms_type;
   typedef logic [1:0]           motor_type;
   typedef logic [6:0]           count_type;
   typedef logic [DEPTH_W-1:0]   depth_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam dist_type NO_ECHO = 10'd999;

   localparam motor_type MOTOR_STOP = 2'd0;
   localparam motor_type MOTOR_CW   = 2'd1;
   localparam motor_type MOTOR_CCW  = 2'd2;

   localparam csr_idx_type CSR_OBSTACLE = 3'd0;
   localparam csr_idx_type CSR_CENTER   = 3'd1;
   localparam csr_idx_type CSR_SETTLE   = 3'd2;
   localparam csr_idx_type CSR_QUARTER  = 3'd3;
   localparam csr_idx_type CSR_HALF     = 3'd4;

   localparam dist_type RST_OBSTACLE = 10'd20;
   localparam tol_type  RST_CENTER   = 8'd3;
   localparam ms_type   RST_SETTLE   = 16'd300;
   localparam ms_type   RST_QUARTER  = 16'd600;
   localparam ms_type   RST_HALF     = 16'd1200;

   typedef enum logic [3:0] {
      PH_DRIVE        = 4'd0,
      PH_SETTLE       = 4'd1,
      PH_TURN_R       = 4'd2,
      PH_TURN_L       = 4'd3,
      PH_DEAD_SETTLE  = 4'd4,
      PH_HALF         = 4'd5,
      PH_AFTER_SETTLE = 4'd6,
      PH_RET_DRIVE    = 4'd7,
      PH_RET_SETTLE   = 4'd8,
      PH_INV_TURN     = 4'd9,
      PH_HALT         = 4'd10
   } phase_type;

   typedef struct packed {
      dist_type obstacle_dist;
      tol_type  center_tol;
      ms_type   settle;
      ms_type   quarter_turn;
      ms_type   half_turn;
   } cfg_type;

   // Turn bits on the stack: 0 is a right turn, 1 a left turn.
   typedef struct packed {
      logic push;
      logic pop;
      logic turn_bit;
   } stack_cmd_type;

   typedef struct packed {
      logic      top_bit;
      depth_type depth;
      logic      full;
   } stack_stat_type;

   typedef struct packed {
      logic shift_down;
      logic shift_up;
   } cell_shift_type;

   typedef struct packed {
      motor_type right_wheel;
      motor_type left_wheel;
      logic [3:0] phase;
      logic       halted;
      count_type  turns_logged;
   } rsp_type;

endpackage

[sv/mnb_if.sv]
// Channel interfaces for distance ticks and motor results.
interface mnb_req_if;
   logic              valid;
   logic              ready;
   mnb_pkg::dist_type front_cm;
   mnb_pkg::dist_type right_cm;
   mnb_pkg::dist_type left_cm;

   modport source (output valid, output front_cm, output right_cm, output left_cm,
                   input ready);
   modport sink   (input valid, input front_cm, input right_cm, input left_cm,
                   output ready);
endinterface

interface mnb_rsp_if;
   logic               valid;
   logic               ready;
   mnb_pkg::motor_type right_wheel;
   mnb_pkg::motor_type left_wheel;
   logic [3:0]         phase;
   logic               halted;
   mnb_pkg::count_type turns_logged;

   modport source (output valid, output right_wheel, output left_wheel, output phase,
                   output halted, output turns_logged, input ready);
   modport sink   (input valid, input right_wheel, input left_wheel, input phase,
                   input halted, input turns_logged, output ready);
endinterface

[sv/maze_navigation_backtrack_fsm.sv]
// Top level: configuration registers, controller, turn stack and result buffer.
//
//   channel  dir  transfer condition        contents
//   req_     in   valid & ready             front_cm, right_cm, left_cm
//   rsp_     out  valid & ready             right_wheel, left_wheel, phase, halted,
//                                           turns_logged
//   csr_     in   csr_we                    csr_index, csr_wdata
//
// One tick can be taken in every cycle while req_chan.ready is high.
// The result of a tick is registered in the result buffer and is offered on rsp_ once it is the head entry.
// A two-entry result buffer keeps req_chan.ready high while one result waits;
// ready drops only when both entries are full.
// Synchronous active-high reset; the stack comes up empty with no clearing pass.
module maze_navigation_backtrack_fsm (
   input  logic                        clock,
   input  logic                        reset,
   mnb_req_if.sink                     req_chan,
   mnb_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  mnb_pkg::csr_idx_type        csr_index,
   input  logic [mnb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mnb_pkg::*;

   cfg_type        cfg_ff;
   stack_cmd_type  cmd;
   stack_stat_type stat;
   rsp_type        result;
   logic           step;

   rsp_type head_ff, skid_ff;
   logic    head_v_ff, head_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type head_in;
   logic    pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_dist <= RST_OBSTACLE;
         cfg_ff.center_tol    <= RST_CENTER;
         cfg_ff.settle        <= RST_SETTLE;
         cfg_ff.quarter_turn  <= RST_QUARTER;
         cfg_ff.half_turn     <= RST_HALF;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OBSTACLE: cfg_ff.obstacle_dist <= csr_wdata[9:0];
            CSR_CENTER:   cfg_ff.center_tol    <= csr_wdata[7:0];
            CSR_SETTLE:   cfg_ff.settle        <= csr_wdata;
            CSR_QUARTER:  cfg_ff.quarter_turn  <= csr_wdata;
            CSR_HALF:     cfg_ff.half_turn     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   assign req_chan.ready = !skid_v_ff;
   assign step           = req_chan.valid && !skid_v_ff;
   assign pop            = rsp_chan.ready && head_v_ff;

   mnb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .front_cm (req_chan.front_cm),
      .right_cm (req_chan.right_cm),
      .left_cm  (req_chan.left_cm),
      .cfg      (cfg_ff),
      .stat     (stat),
      .cmd      (cmd),
      .result   (result)
   );

   mnb_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // The skid entry fills only when the head is held and a new tick arrives.
   always_comb begin
      head_in   = head_ff;
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (pop) begin
            head_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (step) begin
         if (!head_v_ff || pop) begin
            head_in   = result;
            head_v_in = 1'b1;
         end else begin
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         head_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (step && !skid_v_ff && head_v_ff && !pop) begin
         skid_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   assign rsp_chan.valid        = head_v_ff;
   assign rsp_chan.right_wheel  = head_ff.right_wheel;
   assign rsp_chan.left_wheel   = head_ff.left_wheel;
   assign rsp_chan.phase        = head_ff.phase;
   assign rsp_chan.halted       = head_ff.halted;
   assign rsp_chan.turns_logged = head_ff.turns_logged;

   a_skid_has_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> head_v_ff)
      else $error("skid entry holds a result ahead of the head entry");

   a_drain_keeps_head: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_v_ff) |=> (head_v_ff && !skid_v_ff))
      else $error("waiting result lost when the head was taken");

endmodule

[sv/mnb_cell.sv]
// One cell of the turn stack: holds a single turn bit.
module mnb_cell (
   input  logic                    clock,
   input  mnb_pkg::cell_shift_type shift,
   input  logic                    from_above,
   input  logic                    from_below,
   output logic                    bit_out
);
   import mnb_pkg::*;

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (shift.shift_down) begin
         bit_in = from_above;
      end else if (shift.shift_up) begin
         bit_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

[sv/mnb_stack.sv]
// Turn stack built as a row of shifting cells; cell zero is the top.
module mnb_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  mnb_pkg::stack_cmd_type  cmd,
   output mnb_pkg::stack_stat_type stat
);
   import mnb_pkg::*;

   logic [LOG_DEPTH-1:0] cell_bits;
   depth_type            depth_ff;
   depth_type            depth_in;
   logic                 full;
   cell_shift_type       shift;

   assign full             = (depth_ff == DEPTH_W'(LOG_DEPTH));
   assign shift.shift_down = cmd.push && !full;
   assign shift.shift_up   = cmd.pop;

   for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
      logic above;
      logic below;
      if (i == 0) begin : g_top
         assign above = cmd.turn_bit;
      end else begin : g_mid
         assign above = cell_bits[i-1];
      end
      if (i == LOG_DEPTH - 1) begin : g_bottom
         assign below = 1'b0;
      end else begin : g_inner
         assign below = cell_bits[i+1];
      end
      mnb_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .bit_out    (cell_bits[i])
      );
   end

   always_comb begin
      depth_in = depth_ff;
      if (shift.shift_down) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (shift.shift_up) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign stat.top_bit = cell_bits[0];
   assign stat.depth   = depth_ff;
   assign stat.full    = full;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(LOG_DEPTH))
      else $error("turn stack depth beyond capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (depth_ff != '0) && !cmd.push)
      else $error("pop from an empty stack or together with a push");

endmodule

[sv/mnb_ctrl.sv]
// Phase sequencer, tick timer, wall centering and motor decode.
module mnb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  mnb_pkg::dist_type       front_cm,
   input  mnb_pkg::dist_type       right_cm,
   input  mnb_pkg::dist_type       left_cm,
   input  mnb_pkg::cfg_type        cfg,
   input  mnb_pkg::stack_stat_type stat,
   output mnb_pkg::stack_cmd_type  cmd,
   output mnb_pkg::rsp_type        result
);
   import mnb_pkg::*;

   phase_type phase_ff, phase_in;
   ms_type    wait_ff, wait_in;
   logic      returning_ff, returning_in;
   logic      pending_ff, pending_in;

   logic          wall, r_open, l_open;
   logic          timed;
   ms_type        dur;
   ms_type        wait_inc;
   logic          hit;
   logic          stack_busy;
   stack_cmd_type cmd_raw;
   motor_type     rw, lw, cen_rw, cen_lw;
   depth_type     depth_next;

   assign wall   = (front_cm != NO_ECHO) && (front_cm < cfg.obstacle_dist);
   assign r_open = (right_cm != NO_ECHO) && (right_cm >= cfg.obstacle_dist);
   assign l_open = (left_cm != NO_ECHO) && (left_cm >= cfg.obstacle_dist);
   assign stack_busy = (stat.depth != '0);

   // Centering steers only when both side sensors see a wall.
   always_comb begin
      cen_rw = MOTOR_CW;
      cen_lw = MOTOR_CW;
      if (right_cm != NO_ECHO && left_cm != NO_ECHO) begin
         if (({1'b0, right_cm} + {3'b000, cfg.center_tol}) < {1'b0, left_cm}) begin
            cen_rw = MOTOR_STOP;
         end else if (({1'b0, left_cm} + {3'b000, cfg.center_tol}) < {1'b0, right_cm}) begin
            cen_lw = MOTOR_STOP;
         end
      end
   end

   always_comb begin
      timed = 1'b1;
      dur   = cfg.settle;
      case (phase_ff)
         PH_SETTLE, PH_DEAD_SETTLE, PH_AFTER_SETTLE, PH_RET_SETTLE: dur = cfg.settle;
         PH_TURN_R, PH_TURN_L, PH_INV_TURN:                         dur = cfg.quarter_turn;
         PH_HALF:                                                   dur = cfg.half_turn;
         default:                                                   timed = 1'b0;
      endcase
   end

   // The tick count saturates; the tick that reaches the duration ends the phase.
   assign wait_inc = (wait_ff == '1) ? wait_ff : wait_ff + 16'd1;
   assign hit      = (wait_inc >= dur);

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      returning_in = returning_ff;
      pending_in   = pending_ff;
      cmd_raw      = '0;
      if (timed) begin
         wait_in = hit ? '0 : wait_inc;
      end
      case (phase_ff)
         PH_SETTLE: begin
            if (hit) begin
               if (r_open) begin
                  cmd_raw.push = 1'b1;
                  phase_in     = PH_TURN_R;
               end else if (l_open) begin
                  cmd_raw.push     = 1'b1;
                  cmd_raw.turn_bit = 1'b1;
                  phase_in         = PH_TURN_L;
               end else begin
                  phase_in = PH_DEAD_SETTLE;
               end
            end
         end
         PH_TURN_R, PH_TURN_L: begin
            if (hit) phase_in = PH_DRIVE;
         end
         PH_DEAD_SETTLE: begin
            if (hit) phase_in = PH_HALF;
         end
         PH_HALF: begin
            if (hit) phase_in = PH_AFTER_SETTLE;
         end
         PH_AFTER_SETTLE: begin
            if (hit) begin
               if (stack_busy) begin
                  phase_in = PH_RET_DRIVE;
               end else begin
                  returning_in = 1'b1;
                  phase_in     = PH_DRIVE;
               end
            end
         end
         PH_RET_DRIVE: begin
            if (wall) begin
               phase_in = PH_RET_SETTLE;
               wait_in  = '0;
            end
         end
         PH_RET_SETTLE: begin
            if (hit) begin
               if (stack_busy) begin
                  cmd_raw.pop = 1'b1;
                  pending_in  = ~stat.top_bit;
                  phase_in    = PH_INV_TURN;
               end else begin
                  returning_in = 1'b1;
                  phase_in     = PH_DRIVE;
               end
            end
         end
         PH_INV_TURN: begin
            if (hit) begin
               if (stack_busy) begin
                  phase_in = PH_RET_DRIVE;
               end else begin
                  returning_in = 1'b1;
                  phase_in     = PH_DRIVE;
               end
            end
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_DRIVE;
            if (wall) begin
               if (returning_ff) begin
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_SETTLE;
                  wait_in  = '0;
               end
            end
         end
      endcase
   end

   // Motor outputs.
   always_comb begin
      rw = MOTOR_STOP;
      lw = MOTOR_STOP;
      case (phase_ff)
         PH_SETTLE: begin
            if (hit && r_open) begin
               rw = MOTOR_CCW;
               lw = MOTOR_CW;
            end else if (hit && l_open) begin
               rw = MOTOR_CW;
               lw = MOTOR_CCW;
            end
         end
         PH_TURN_R: begin
            rw = MOTOR_CCW;
            lw = MOTOR_CW;
         end
         PH_TURN_L: begin
            rw = MOTOR_CW;
            lw = MOTOR_CCW;
         end
         PH_DEAD_SETTLE: begin
            if (hit) begin
               rw = MOTOR_CCW;
               lw = MOTOR_CW;
            end
         end
         PH_HALF: begin
            if (!hit) begin
               rw = MOTOR_CCW;
               lw = MOTOR_CW;
            end
         end
         PH_AFTER_SETTLE: begin
            if (hit && stack_busy) begin
               rw = MOTOR_CW;
               lw = MOTOR_CW;
            end
         end
         PH_RET_DRIVE: begin
            if (!wall) begin
               rw = cen_rw;
               lw = cen_lw;
            end
         end
         PH_RET_SETTLE: begin
            if (hit && stack_busy) begin
               rw = stat.top_bit ? MOTOR_CCW : MOTOR_CW;
               lw = stat.top_bit ? MOTOR_CW : MOTOR_CCW;
            end
         end
         PH_INV_TURN: begin
            rw = pending_ff ? MOTOR_CW : MOTOR_CCW;
            lw = pending_ff ? MOTOR_CCW : MOTOR_CW;
         end
         PH_HALT: begin
            rw = MOTOR_STOP;
            lw = MOTOR_STOP;
         end
         default: begin
            if (!wall) begin
               rw = cen_rw;
               lw = cen_lw;
            end
         end
      endcase
   end

   always_comb begin
      depth_next = stat.depth;
      if (cmd_raw.push && !stat.full) begin
         depth_next = stat.depth + DEPTH_W'(1);
      end else if (cmd_raw.pop) begin
         depth_next = stat.depth - DEPTH_W'(1);
      end
   end

   assign cmd.push     = cmd_raw.push && step;
   assign cmd.pop      = cmd_raw.pop && step;
   assign cmd.turn_bit = cmd_raw.turn_bit;

   assign result.right_wheel  = rw;
   assign result.left_wheel   = lw;
   assign result.phase        = phase_in;
   assign result.halted       = (phase_in == PH_HALT);
   assign result.turns_logged = 7'(depth_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DRIVE;
         wait_ff      <= '0;
         returning_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         returning_ff <= returning_in;
         pending_ff   <= pending_in;
      end
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("left the parked phase");

   a_halt_needs_return: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |-> returning_ff)
      else $error("parked without a finished return trip");

endmodule
